// ----- design/text_line_folder_defines.svh -----
// ---------------------------------------------------------------------------
// Text line folder assertion macros
// Shared property macros for the checkers of the text line folder. Each
// macro samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_LINE_FOLDER_DEFINES_SVH
`define TEXT_LINE_FOLDER_DEFINES_SVH

// Consequent is checked in the same cycle as the antecedent.
`define TLF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text_line_folder check failed");

// Consequent is checked in the cycle after the antecedent.
`define TLF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text_line_folder check failed");

`endif

// ----- design/tlf_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text line folder package
// Line geometry, character codes and the line memory request type.
// ---------------------------------------------------------------------------
package tlf_pkg;

    localparam int LINE_WIDTH = 50;
    localparam int TAB_WIDTH  = 8;

    // Address of one line buffer entry, and a count that can hold LINE_WIDTH.
    localparam int ADDR_W = $clog2(LINE_WIDTH);
    localparam int CNT_W  = $clog2(LINE_WIDTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    // Column within the current tab stop.
    localparam int PH_W   = $clog2(TAB_WIDTH + 1);

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_BLANK = 8'd32;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ----- design/text_line_folder.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text line folder
// Folds a text byte stream into lines of at most LINE_WIDTH characters.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_byte takes one character per transfer.
// Output channel out_valid/out_stall/out_byte/run_end gives the folded text;
// run_end marks the newline that closes the bytes caused by one input.
// An ordinary character that does not fill the line is stored at once and the
// block is ready again in the next cycle. A tab stores its blanks one by one
// up to the next tab stop or the end of the line. A line is emitted one
// character at a time and closed with a newline, after a fold decision when
// the line filled; every character goes through the single read port of the
// line memory, whose read data is registered before it reaches the output
// register. The input is stalled while a tab is expanded or a line is emitted.
// A stalled output byte holds in the output register and the sequencer waits.
// Reset clears the column count and control state; buffer contents are
// undefined until written and need no clearing pass. A partial line is kept
// until a newline or a full line pushes it out.
// ---------------------------------------------------------------------------
module text_line_folder
    import tlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_end
);

    mem_req_t   mem_req;
    logic [7:0] rd_data;

    tlf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_end   (run_end),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    tlf_line_mem u_line_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// ----- design/tlf_line_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text line folder line memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module tlf_line_mem
    import tlf_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [LINE_WIDTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/tlf_seq.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text line folder sequencer
// Steps through tab expansion, line folding and line emission, driving the
// line memory through circular address arithmetic.
// ---------------------------------------------------------------------------
module tlf_seq
    import tlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_end,
    output mem_req_t   mem_req,
    input  logic [7:0] rd_data
);

    localparam int W_MOD = LINE_WIDTH % TAB_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAB,
        S_FOLD,
        S_RD,
        S_OUT,
        S_NL
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              blank_vld_reg, blank_vld_next;
    logic [ADDR_W-1:0] blank_idx_reg, blank_idx_next;
    logic [PH_W-1:0]   blank_ph_reg, blank_ph_next;
    logic [ADDR_W-1:0] emit_idx_reg, emit_idx_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  newpos_reg, newpos_next;
    logic [PH_W-1:0]   newph_reg, newph_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              run_end_reg, run_end_next;

    logic              slot_free;
    logic [CNT_W-1:0]  pos_inc;
    logic [PH_W-1:0]   phase_inc;
    logic [PH_W-1:0]   fold_ph;

    // The buffer is circular: logical column i lives at base + i, wrapped.
    function automatic logic [ADDR_W-1:0] mod_add(input logic [ADDR_W-1:0] a,
                                                  input logic [CNT_W-1:0]  b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(LINE_WIDTH))
        begin
            s = s - SUM_W'(LINE_WIDTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    assign slot_free = !out_valid_reg || !out_stall;
    assign pos_inc   = pos_reg + 1'b1;
    assign phase_inc = (phase_reg == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_reg + 1'b1;

    // Tab column of the remainder after a fold: (LINE_WIDTH - (b + 1)) mod TAB_WIDTH,
    // where the tab column of b + 1 was recorded when the blank was stored.
    assign fold_ph = (PH_W'(W_MOD) >= blank_ph_reg) ? PH_W'(W_MOD) - blank_ph_reg
                                                     : PH_W'(W_MOD + TAB_WIDTH) - blank_ph_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        base_next      = base_reg;
        blank_vld_next = blank_vld_reg;
        blank_idx_next = blank_idx_reg;
        blank_ph_next  = blank_ph_reg;
        emit_idx_next  = emit_idx_reg;
        len_next       = len_reg;
        newpos_next    = newpos_reg;
        newph_next     = newph_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        run_end_next   = run_end_reg;
        mem_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_byte == CH_TAB)
                    begin
                        state_next = S_TAB;
                    end
                    else if (in_byte == CH_NL)
                    begin
                        if (pos_reg != '0)
                        begin
                            len_next      = pos_reg;
                            newpos_next   = '0;
                            newph_next    = '0;
                            emit_idx_next = '0;
                            state_next    = S_RD;
                        end
                    end
                    else
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = mod_add(base_reg, pos_reg);
                        mem_req.wr_data = in_byte;
                        pos_next        = pos_inc;
                        phase_next      = phase_inc;
                        // Only a blank at column 1 or above can serve as a break.
                        if (in_byte == CH_BLANK && pos_reg != '0)
                        begin
                            blank_vld_next = 1'b1;
                            blank_idx_next = pos_reg[ADDR_W-1:0];
                            blank_ph_next  = phase_inc;
                        end
                        if (pos_inc == CNT_W'(LINE_WIDTH))
                        begin
                            state_next = S_FOLD;
                        end
                    end
                end
            end
            S_TAB:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = mod_add(base_reg, pos_reg);
                mem_req.wr_data = CH_BLANK;
                pos_next        = pos_inc;
                phase_next      = phase_inc;
                if (pos_reg != '0)
                begin
                    blank_vld_next = 1'b1;
                    blank_idx_next = pos_reg[ADDR_W-1:0];
                    blank_ph_next  = phase_inc;
                end
                if (pos_inc == CNT_W'(LINE_WIDTH))
                begin
                    len_next      = CNT_W'(LINE_WIDTH);
                    newpos_next   = '0;
                    newph_next    = '0;
                    emit_idx_next = '0;
                    state_next    = S_RD;
                end
                else if (phase_inc == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FOLD:
            begin
                emit_idx_next = '0;
                state_next    = S_RD;
                if (blank_vld_reg)
                begin
                    len_next    = CNT_W'(blank_idx_reg) + 1'b1;
                    newpos_next = CNT_W'(LINE_WIDTH - 1) - CNT_W'(blank_idx_reg);
                    newph_next  = fold_ph;
                end
                else
                begin
                    len_next    = CNT_W'(LINE_WIDTH);
                    newpos_next = '0;
                    newph_next  = '0;
                end
            end
            S_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = mod_add(base_reg, CNT_W'(emit_idx_reg));
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data;
                    run_end_next   = 1'b0;
                    if (CNT_W'(emit_idx_reg) + 1'b1 == len_reg)
                    begin
                        state_next = S_NL;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = S_RD;
                    end
                end
            end
            S_NL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_NL;
                    run_end_next   = 1'b1;
                    // The emitted columns are consumed; what is left starts at the new base.
                    pos_next       = newpos_reg;
                    phase_next     = newph_reg;
                    base_next      = mod_add(base_reg, len_reg);
                    blank_vld_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            phase_reg     <= '0;
            base_reg      <= '0;
            blank_vld_reg <= 1'b0;
            blank_idx_reg <= '0;
            blank_ph_reg  <= '0;
            emit_idx_reg  <= '0;
            len_reg       <= '0;
            newpos_reg    <= '0;
            newph_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            run_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            blank_vld_reg <= blank_vld_next;
            blank_idx_reg <= blank_idx_next;
            blank_ph_reg  <= blank_ph_next;
            emit_idx_reg  <= emit_idx_next;
            len_reg       <= len_next;
            newpos_reg    <= newpos_next;
            newph_reg     <= newph_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            run_end_reg   <= run_end_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_end   = run_end_reg;

endmodule

// ----- design/tlf_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text line folder checker
// Port-level properties of the text line folder, bound to the top level.
// ---------------------------------------------------------------------------
`include "text_line_folder_defines.svh"

module tlf_checker
    import tlf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_end
);

    // A stalled output transfer keeps its payload.
    `TLF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(out_byte) && $stable(run_end))

    // The byte that closes a run of output bytes is always a newline.
    `TLF_ASSERT_NOW(a_end_is_nl, out_valid && run_end, out_byte == CH_NL)

    // Output appears only while the block is busy with an item.
    `TLF_ASSERT_NOW(a_out_from_busy, $rose(out_valid), $past(in_stall))

    // While a line is still being emitted, no new input is taken.
    `TLF_ASSERT_NOW(a_mid_line_busy, out_valid && !run_end, in_stall)

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_end   (run_end)
);

// ----- test/text_line_folder_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Text line folder testbench
// Feeds directed and random text into the folder and scores the folded
// output. Each accepted input byte is folded in the testbench's own copy of
// the line buffer, and every output transfer is compared with the oldest
// byte still owed. Both sides idle at random, the receiver once holds off
// long enough to back the block up, and the sender once waits for the
// output to drain.
// ---------------------------------------------------------------------------
module text_line_folder_tb;
    import tlf_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } folded_t;

    typedef struct {
        logic [7:0] ch;
        int         gap;
        bit         drain;
    } text_item_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_end;

    text_item_t text_q[$];
    folded_t    folded_q[$];
    logic [7:0] line_buf[LINE_WIDTH];
    int         line_fill;
    int         failures;
    int         chars_taken;
    int         gap_left;
    int         hold_left;
    int         cycle_no;
    bit         long_hold_done;
    bit         calm;
    bit         drain_next;
    folded_t    got_want;

    text_line_folder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_end   (run_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Owe the first len buffered characters followed by the closing newline.
    task automatic owe_line(input int len);
        int i;
        for (i = 0; i < len; i++)
            folded_q.push_back('{ch: line_buf[i], last: 1'b0});
        folded_q.push_back('{ch: CH_NL, last: 1'b1});
    endtask

    task automatic fold_char(input logic [7:0] ch);
        int col;
        int b;
        int keep;
        int i;
        col = line_fill;
        if (ch == CH_TAB)
        begin
            do
            begin
                line_buf[col] = CH_BLANK;
                col++;
            end
            while (col < LINE_WIDTH && (col % TAB_WIDTH) != 0);
            if (col >= LINE_WIDTH)
            begin
                owe_line(LINE_WIDTH);
                col = 0;
            end
        end
        else if (ch == CH_NL)
        begin
            if (col > 0)
                owe_line(col);
            col = 0;
        end
        else
        begin
            line_buf[col] = ch;
            col++;
            if (col >= LINE_WIDTH)
            begin
                // A blank in the first column never counts as a break point.
                b = LINE_WIDTH - 1;
                while (b >= 1 && line_buf[b] != CH_BLANK)
                    b--;
                if (b >= 1)
                begin
                    keep = LINE_WIDTH - 1 - b;
                    owe_line(b + 1);
                    for (i = 0; i < keep; i++)
                        line_buf[i] = line_buf[b + 1 + i];
                    col = keep;
                end
                else
                begin
                    owe_line(LINE_WIDTH);
                    col = 0;
                end
            end
        end
        line_fill = col;
    endtask

    task automatic add_char(input logic [7:0] ch);
        text_q.push_back('{ch: ch, gap: calm ? 0 : pick_gap(), drain: drain_next});
        drain_next = 1'b0;
    endtask

    task automatic add_word(input int len);
        int i;
        for (i = 0; i < len; i++)
            add_char(8'($urandom_range(33, 126)));
    endtask

    // Sender: offers the queued text, holding each byte until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'd0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                fold_char(in_byte);
                chars_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (text_q.size() == 0)
                    in_valid <= 1'b0;
                else if (text_q[0].drain && folded_q.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    in_valid <= 1'b1;
                    in_byte  <= text_q[0].ch;
                    gap_left <= text_q[0].gap;
                    void'(text_q.pop_front());
                end
            end
        end
    end

    // Receiver: scores each output transfer and drives the stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall      <= 1'b0;
            hold_left      <= 0;
            cycle_no       <= 0;
            long_hold_done <= 1'b0;
        end
        else
        begin
            cycle_no <= cycle_no + 1;
            if (out_valid && !out_stall)
            begin
                if (folded_q.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %0d run_end %0b", out_byte, run_end);
                    failures++;
                end
                else
                begin
                    got_want = folded_q.pop_front();
                    if (out_byte !== got_want.ch)
                    begin
                        $error("out_byte: expected %0d, actual %0d", got_want.ch, out_byte);
                        failures++;
                    end
                    if (run_end !== got_want.last)
                    begin
                        $error("run_end: expected %0b, actual %0b", got_want.last, run_end);
                        failures++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!long_hold_done && chars_taken >= 80)
            begin
                // Long hold-off so that the block backs up into its input.
                out_stall      <= 1'b1;
                hold_left      <= 500;
                long_hold_done <= 1'b1;
            end
            else if ((cycle_no / 400) % 4 == 1)
                out_stall <= 1'b0;
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:64]:  out_stall <= 1'b0;
                    [65:94]:
                    begin
                        out_stall <= 1'b1;
                        hold_left <= $urandom_range(0, 2);
                    end
                    default:
                    begin
                        out_stall <= 1'b1;
                        hold_left <= $urandom_range(10, 30);
                    end
                endcase
            end
        end
    end

    initial
    begin
        int n_random;
        int kind;
        int i;
        bit drained;

        line_fill   = 0;
        failures    = 0;
        chars_taken = 0;
        calm        = 1'b0;
        drain_next  = 1'b0;
        drained     = 1'b0;

        // Directed: newline on an empty line, extreme bytes, tabs inside a
        // stop and on a stop, a flush, then tabs that run into the width.
        add_char(CH_NL);
        add_char(8'h00);
        add_char(8'hFF);
        add_char("a");
        add_char(CH_BLANK);
        add_char(CH_TAB);
        add_char(CH_TAB);
        add_char("x");
        add_char(CH_NL);
        add_char(CH_NL);
        add_char(8'h7F);
        add_char(8'h80);
        add_char(8'h55);
        add_char(8'hAA);
        for (i = 0; i < 7; i++)
            add_char(CH_TAB);
        add_char("z");
        add_char(CH_NL);

        // A full line whose only blank sits in the first column.
        add_char(CH_BLANK);
        add_word(LINE_WIDTH - 1);
        n_random = text_q.size();

        while (n_random < 260)
        begin
            if ($urandom_range(0, 29) == 0)
                calm = !calm;
            if (!drained && n_random >= 150)
            begin
                drain_next = 1'b1;
                drained    = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                i = $urandom_range(1, 9);
                add_word(i);
                add_char(CH_BLANK);
                n_random += i + 1;
            end
            else if (kind < 63)
            begin
                add_char(CH_TAB);
                n_random++;
            end
            else if (kind < 70)
            begin
                add_char(CH_NL);
                n_random++;
            end
            else if (kind < 75)
            begin
                i = $urandom_range(40, 70);
                add_word(i);
                n_random += i;
            end
            else if (kind < 90)
            begin
                add_char(8'($urandom_range(0, 255)));
                n_random++;
            end
            else
            begin
                add_char(CH_BLANK);
                n_random++;
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_q.size() != 0 || in_valid)
            @(posedge clk);
        while (folded_q.size() != 0)
            @(posedge clk);
        // A trailing tab or a line still being read out may yet be in flight.
        repeat (250) @(posedge clk);
        if (folded_q.size() != 0)
        begin
            $error("%0d folded bytes never arrived", folded_q.size());
            failures++;
        end
        if (failures == 0)
            $display("text_line_folder regression: pass");
        else
            $display("text_line_folder regression: fail");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("text_line_folder regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/tlf_pkg.sv
design/tlf_line_mem.sv
design/tlf_seq.sv
design/text_line_folder.sv
design/tlf_checker.sv
test/text_line_folder_tb.sv
